// File: design/bafd_pkg.sv
// ----------------------------------------------------------------------------
// bafd_pkg: shared types and constants of the attitude frame decoder
// Frame positions, the record handed from the byte front end to the angle
// back end, and the queue status bundle.
// ----------------------------------------------------------------------------
package bafd_pkg;

  // Frame layout
  localparam int unsigned AngleCount = 9;            // captured bytes 4..12
  localparam int unsigned PosW       = 4;
  localparam logic [PosW-1:0] PosIdle       = 4'd0;  // waiting for frame start
  localparam logic [PosW-1:0] PosFirst      = 4'd1;  // next byte is byte 1
  localparam logic [PosW-1:0] PosAngleFirst = 4'd4;  // first angle byte
  localparam logic [PosW-1:0] PosLast       = 4'd13; // checksum byte

  // Output field widths and the packed output word
  localparam int unsigned SignedAngleW = 19;
  localparam int unsigned HeadingW     = 18;
  localparam int unsigned OutDataW     = 64;

  typedef logic [7:0] octet_t;

  // One finished frame: checksum verdict and the raw angle bytes
  typedef struct packed {
    logic                         ok;
    logic [AngleCount-1:0][7:0]   angle;
  } frame_rec_t;

  // Front end to queue
  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } push_t;

  // Queue status: full gates the input, empty is seen by the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: design/bafd_front.sv
// ----------------------------------------------------------------------------
// bafd_front: byte front end
// Tracks the frame position, sums bytes 1..12, captures the angle bytes and
// hands a finished frame record to the queue when the checksum byte arrives.
// ----------------------------------------------------------------------------
module bafd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  bafd_pkg::octet_t rx_byte,
  input  logic            frame_start,
  output bafd_pkg::push_t push
);
  import bafd_pkg::*;

  localparam int unsigned IdxW = $clog2(AngleCount);

  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;
  octet_t          sum;
  octet_t          sum_next;
  octet_t          angle_bytes [AngleCount];
  logic            body_byte;
  logic            capture;
  logic [PosW-1:0] cap_off;

  // Classify the incoming byte
  assign body_byte = in_fire && !frame_start && (pos != PosIdle) && (pos < PosLast);
  assign capture   = body_byte && (pos >= PosAngleFirst);
  assign cap_off   = pos - PosAngleFirst;

  // Position and running sum
  always_comb begin
    pos_next = pos;
    sum_next = sum;
    if (in_fire) begin
      if (frame_start) begin
        pos_next = PosFirst;
        sum_next = '0;
      end else if (pos == PosIdle || pos > PosLast) begin
        pos_next = PosIdle;
      end else if (pos < PosLast) begin
        pos_next = pos + PosW'(1);
        sum_next = sum + rx_byte;
      end else begin
        pos_next = PosIdle;
        sum_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= PosIdle;
      sum <= '0;
    end else begin
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  // Capture angle bytes 4..12
  always_ff @(posedge clk) begin
    if (capture) begin
      angle_bytes[cap_off[IdxW-1:0]] <= rx_byte;
    end
  end

  // Hand the frame over on the checksum byte
  always_comb begin
    push.valid  = in_fire && !frame_start && (pos == PosLast);
    push.rec.ok = (sum == rx_byte);
    for (int i = 0; i < AngleCount; i++) begin
      push.rec.angle[i] = angle_bytes[i];
    end
  end

endmodule

// File: design/bafd_queue.sv
// ----------------------------------------------------------------------------
// bafd_queue: frame record queue
// Short FIFO between front and back end so that each side stalls on its own.
// ----------------------------------------------------------------------------
module bafd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bafd_pkg::push_t      push,
  input  logic                 pop,
  output bafd_pkg::frame_rec_t head,
  output bafd_pkg::q_stat_t    stat
);
  import bafd_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  frame_rec_t      mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign stat.full  = (count == CntW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.rec;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/bafd_back.sv
// ----------------------------------------------------------------------------
// bafd_back: angle back end
// Decodes the packed BCD angles of a frame record, keeps the last good
// angles and presents the result in an output register.
// ----------------------------------------------------------------------------
module bafd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bafd_pkg::frame_rec_t          head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bafd_pkg::OutDataW-1:0] out_data
);
  import bafd_pkg::*;

  localparam logic [HeadingW-1:0] W4 = 18'd10000;
  localparam logic [HeadingW-1:0] W3 = 18'd1000;
  localparam logic [HeadingW-1:0] W2 = 18'd100;
  localparam logic [HeadingW-1:0] W1 = 18'd10;
  localparam int unsigned PadW = OutDataW - 1 - 2 * SignedAngleW - HeadingW;

  typedef logic signed [SignedAngleW-1:0] sangle_t;

  sangle_t             last_pitch;
  sangle_t             last_roll;
  logic [HeadingW-1:0] last_heading;
  sangle_t             pitch_new;
  sangle_t             roll_new;
  logic [HeadingW-1:0] heading_new;
  sangle_t             pitch_out;
  sangle_t             roll_out;
  logic [HeadingW-1:0] heading_out;

  // Five digits weighted by place; non-BCD nibbles keep their raw weight
  function automatic logic [HeadingW-1:0] bcd_mag(input octet_t a, input octet_t b,
                                                  input octet_t c);
    bcd_mag = HeadingW'(a[3:0]) * W4 + HeadingW'(b[7:4]) * W3 + HeadingW'(b[3:0]) * W2
            + HeadingW'(c[7:4]) * W1 + HeadingW'(c[3:0]);
  endfunction

  function automatic sangle_t signed_angle(input octet_t a, input octet_t b,
                                           input octet_t c);
    sangle_t m;
    m = sangle_t'({1'b0, bcd_mag(a, b, c)});
    signed_angle = a[4] ? -m : m;
  endfunction

  // Take a record whenever the output register is free or being drained
  assign pop = !q_empty && (!out_valid || out_ready);

  assign pitch_new   = signed_angle(head.angle[0], head.angle[1], head.angle[2]);
  assign roll_new    = signed_angle(head.angle[3], head.angle[4], head.angle[5]);
  assign heading_new = bcd_mag(head.angle[6], head.angle[7], head.angle[8]);

  assign pitch_out   = head.ok ? pitch_new   : last_pitch;
  assign roll_out    = head.ok ? roll_new    : last_roll;
  assign heading_out = head.ok ? heading_new : last_heading;

  // Hold last good angles
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pitch   <= '0;
      last_roll    <= '0;
      last_heading <= '0;
    end else if (pop && head.ok) begin
      last_pitch   <= pitch_new;
      last_roll    <= roll_new;
      last_heading <= heading_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {PadW'(0), heading_out, roll_out, pitch_out, head.ok};
    end
  end

endmodule

// File: design/bcd_attitude_frame_decoder.sv
// ----------------------------------------------------------------------------
// bcd_attitude_frame_decoder: attitude compass reply frame decoder
// Takes a 14-byte compass reply one byte per transfer, checks the modulo-256
// sum of bytes 1..12 against byte 13 and emits pitch, roll and heading in
// hundredths of a degree, holding the last good angles on a checksum error.
//
//  channel  | dir | contents
//  ---------+-----+-------------------------------------------------------
//  s_axis   | in  | tdata: rx_byte[7:0]; tuser: frame_start
//  m_axis   | out | tdata: checksum_ok, pitch, roll, heading, zero pad
//
// One byte is taken every cycle while the record queue is not full; the
// byte front end needs one add and one capture per byte. A result passes
// through the record queue, then the BCD decode and output register.
// Reset clears position, sum, queue and last good angles; no clearing pass.
// A stalled output fills the record queue; input stalls only when it is full.
// ----------------------------------------------------------------------------
module bcd_attitude_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2   // frame records in flight, 2..16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  logic                          s_axis_tuser,  // [0] frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] checksum_ok, [19:1] pitch_centideg, [38:20] roll_centideg,
  // [56:39] heading_centideg, [63:57] zero
  output logic [bafd_pkg::OutDataW-1:0] m_axis_tdata
);
  import bafd_pkg::*;

  logic       in_fire;
  push_t      push;
  frame_rec_t head;
  q_stat_t    q_stat;
  logic       pop;

  assign s_axis_tready = !q_stat.full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Byte front end
  bafd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .rx_byte     (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .push        (push)
  );

  // Record queue
  bafd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (q_stat)
  );

  // Angle back end
  bafd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // A frame record is never handed to a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_stat.full)
    else $error("frame record pushed into full queue");

  // The queue cannot report full and empty at once
  a_full_empty_excl: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // A new result only follows a queued frame record
  a_result_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!q_stat.empty))
    else $error("result raised without a queued frame");
`endif

endmodule
